@@ hdl/tdes_pkg.sv @@
// Package for the descendant edge set builder: sizes, codes and the state type.
// Used by tree_descendant_edge_sets; depends on nothing else.
package tdes_pkg;

    // Row geometry
    localparam int MAX_EDGES  = 256;
    localparam int WORD_BITS  = 64;
    localparam int WORDS      = (MAX_EDGES + WORD_BITS - 1) / WORD_BITS;
    localparam int ROWS       = 256;
    localparam int MEM_DEPTH  = ROWS * WORDS;

    // Derived widths
    localparam int ROW_W      = $clog2(ROWS);
    localparam int WORD_SEL_W = $clog2(WORDS);
    localparam int BIT_SEL_W  = $clog2(WORD_BITS);
    localparam int ADDR_W     = ROW_W + WORD_SEL_W;
    localparam int STEP_W     = $clog2(WORDS + 1);
    localparam int NODE_W     = 9;
    localparam int EDGE_W     = 9;

    // Register reset value
    localparam logic [NODE_W-1:0] TIP_COUNT_RESET = NODE_W'(2);

    // Item kinds
    localparam logic KIND_EDGE = 1'b0;
    localparam logic KIND_READ = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EDGE,
        ST_RD_ISSUE,
        ST_RD_DATA
    } state_t;

endpackage

@@ hdl/tree_descendant_edge_sets.sv @@
// Descendant edge set builder: per internal node, a row of edge flags in one memory.
// Depends on tdes_pkg.
//
// Edge item: the transfer, then one read-modify-write step per word and a
//   final write, bounded by the single write port of the row memory.
// Ignored edge item: transfer only. Read item: memory read into the output register,
//   which holds the result until transferred; the next item may enter meanwhile.
// Reset: control, tip_count (2) and all row valid bits are cleared at once;
//   the row memory itself is not cleared and needs no clearing pass.
module tree_descendant_edge_sets
    import tdes_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [NODE_W-1:0]     cfg_data,
    // input item channel
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  kind,
    input  logic                  new_tree,
    input  logic [EDGE_W-1:0]     edge_number,
    input  logic [NODE_W-1:0]     parent_node,
    input  logic [NODE_W-1:0]     child_node,
    input  logic [ROW_W-1:0]      read_row,
    input  logic [WORD_SEL_W-1:0] read_word,
    // result channel
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [WORD_BITS-1:0]  row_word
);

    // Row memory and its read ports
    logic [WORD_BITS-1:0] mem [MEM_DEPTH];
    logic [WORD_BITS-1:0] rd_a_data_reg;
    logic [WORD_BITS-1:0] rd_b_data_reg;
    logic                 rd_en;
    logic [ADDR_W-1:0]    rd_a_addr;
    logic [ADDR_W-1:0]    rd_b_addr;
    logic                 mem_we;
    logic [ADDR_W-1:0]    wr_addr;
    logic [WORD_BITS-1:0] wr_data;

    // Control and item state
    state_t               state_reg, state_next;
    logic [NODE_W-1:0]    tip_count_reg;
    logic [ROWS-1:0]      row_written_reg, row_written_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic [ROW_W-1:0]     prow_reg, prow_next;
    logic [ROW_W-1:0]     crow_reg, crow_next;
    logic                 pvalid_reg, pvalid_next;
    logic                 cvalid_reg, cvalid_next;
    logic [WORD_SEL_W-1:0] eword_reg, eword_next;
    logic [BIT_SEL_W-1:0] ebit_reg, ebit_next;
    logic [WORD_SEL_W-1:0] rword_reg, rword_next;
    logic                 out_valid_reg, out_valid_next;
    logic [WORD_BITS-1:0] row_word_reg, row_word_next;

    // Decode of the incoming edge
    logic                 in_xfer;
    logic [NODE_W-1:0]    pdiff;
    logic [NODE_W-1:0]    cdiff;
    logic [EDGE_W-1:0]    edge_idx;
    logic                 edge_ok;
    logic                 child_int;
    logic [ROWS-1:0]      written_cleared;
    logic [STEP_W-1:0]    wr_step;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign row_word  = row_word_reg;

    assign pdiff     = parent_node - tip_count_reg - NODE_W'(1);
    assign cdiff     = child_node - tip_count_reg - NODE_W'(1);
    assign edge_idx  = edge_number - EDGE_W'(1);
    assign edge_ok   = (edge_number != '0)
                    && (edge_number <= EDGE_W'(MAX_EDGES))
                    && (parent_node > tip_count_reg)
                    && !pdiff[NODE_W-1];
    assign child_int = (child_node > tip_count_reg) && !cdiff[NODE_W-1];
    assign written_cleared = new_tree ? '0 : row_written_reg;

    // Word being written back lags the word being read by one step
    assign wr_step   = step_reg - STEP_W'(1);

    // Next state and datapath control
    always_comb
    begin
        state_next       = state_reg;
        row_written_next = row_written_reg;
        step_next        = step_reg;
        prow_next        = prow_reg;
        crow_next        = crow_reg;
        pvalid_next      = pvalid_reg;
        cvalid_next      = cvalid_reg;
        eword_next       = eword_reg;
        ebit_next        = ebit_reg;
        rword_next       = rword_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        row_word_next    = row_word_reg;
        rd_en            = 1'b0;
        rd_a_addr        = {prow_reg, step_reg[WORD_SEL_W-1:0]};
        rd_b_addr        = {crow_reg, step_reg[WORD_SEL_W-1:0]};
        mem_we           = 1'b0;
        wr_addr          = {prow_reg, wr_step[WORD_SEL_W-1:0]};
        wr_data          = (pvalid_reg ? rd_a_data_reg : '0)
                         | (cvalid_reg ? rd_b_data_reg : '0);
        if (wr_step[WORD_SEL_W-1:0] == eword_reg)
        begin
            wr_data[ebit_reg] = 1'b1;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (kind == KIND_EDGE)
                    begin
                        row_written_next = written_cleared;
                        prow_next   = pdiff[ROW_W-1:0];
                        crow_next   = cdiff[ROW_W-1:0];
                        pvalid_next = written_cleared[pdiff[ROW_W-1:0]];
                        cvalid_next = child_int && written_cleared[cdiff[ROW_W-1:0]];
                        eword_next  = edge_idx[BIT_SEL_W +: WORD_SEL_W];
                        ebit_next   = edge_idx[BIT_SEL_W-1:0];
                        step_next   = '0;
                        if (edge_ok)
                        begin
                            // parent row becomes live; stale words are masked by pvalid
                            row_written_next[pdiff[ROW_W-1:0]] = 1'b1;
                            state_next = ST_EDGE;
                        end
                    end
                    else
                    begin
                        prow_next   = read_row;
                        rword_next  = read_word;
                        pvalid_next = row_written_reg[read_row];
                        state_next  = ST_RD_ISSUE;
                    end
                end
            end
            ST_EDGE:
            begin
                // read word step, write back word step-1
                rd_en  = (step_reg < STEP_W'(WORDS));
                mem_we = (step_reg != '0);
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(WORDS))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_RD_ISSUE:
            begin
                rd_en      = 1'b1;
                rd_a_addr  = {prow_reg, rword_reg};
                state_next = ST_RD_DATA;
            end
            ST_RD_DATA:
            begin
                // wait until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    row_word_next  = pvalid_reg ? rd_a_data_reg : '0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            tip_count_reg   <= TIP_COUNT_RESET;
            row_written_reg <= '0;
            step_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            row_written_reg <= row_written_next;
            step_reg        <= step_next;
            out_valid_reg   <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                tip_count_reg <= cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        prow_reg     <= prow_next;
        crow_reg     <= crow_next;
        pvalid_reg   <= pvalid_next;
        cvalid_reg   <= cvalid_next;
        eword_reg    <= eword_next;
        ebit_reg     <= ebit_next;
        rword_reg    <= rword_next;
        row_word_reg <= row_word_next;
    end

    // Row memory: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_a_data_reg <= mem[rd_a_addr];
            rd_b_data_reg <= mem[rd_b_addr];
        end
    end

`ifndef SYNTH
    // Step counter never runs past the final write-back
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EDGE |-> step_reg <= STEP_W'(WORDS))
        else $error("edge step counter out of range");

    // Writes only land in a row already marked live
    a_write_live: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == ST_EDGE) && row_written_reg[prow_reg])
        else $error("memory write outside a live edge update");

    // A read item is followed by its memory access
    a_read_seq: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && (kind == KIND_READ) |=> state_reg == ST_RD_ISSUE)
        else $error("read item did not start a memory read");

    // Write-back never targets the word being read in the same cycle
    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we && rd_en |-> (wr_addr != rd_a_addr) && (wr_addr != rd_b_addr))
        else $error("read and write of the same memory word");
`endif

endmodule

@@ dv/tree_descendant_edge_sets_tb.sv @@
// Testbench for tree_descendant_edge_sets: builds random postorder trees and noise,
// predicts every row word read back and checks it. Depends on tdes_pkg and the block RTL.
`timescale 1ns / 100ps

module tree_descendant_edge_sets_tb
    import tdes_pkg::*;
();

    localparam int CLK_HALF        = 5;
    localparam int RESET_CYCLES    = 7;
    localparam int ITEMS_PER_PHASE = 320;
    // an edge keeps the block busy after its transfer, one step per word plus a final write
    localparam int SETTLE_CYCLES   = 12;
    // worst idle stretch is a long output stall plus a drain and settle
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int MAX_REPORTS     = 10;

    // Receiver stall patterns
    localparam int RDY_STEADY = 0;
    localparam int RDY_RANDOM = 1;
    localparam int RDY_STALL  = 2;
    localparam int RDY_TOGGLE = 3;

    typedef struct {
        logic                  kind;
        logic                  new_tree;
        logic [EDGE_W-1:0]     edge_number;
        logic [NODE_W-1:0]     parent_node;
        logic [NODE_W-1:0]     child_node;
        logic [ROW_W-1:0]      read_row;
        logic [WORD_SEL_W-1:0] read_word;
    } row_item_t;

    // Keeps its own copy of the edge-set rows and the words still owed by the block
    class row_word_scoreboard;
        logic [NODE_W-1:0]    tip_count;
        logic [WORD_BITS-1:0] edge_flags [ROWS][WORDS];
        bit                   row_live [ROWS];
        logic [WORD_BITS-1:0] expected_words [$];
        int                   mismatches;
        int                   words_checked;
        int                   edges_applied;

        function new();
            tip_count = TIP_COUNT_RESET;
            foreach (row_live[r])
                row_live[r] = 1'b0;
            mismatches    = 0;
            words_checked = 0;
            edges_applied = 0;
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        // Applies one accepted item; returns 1 when it changes a row or asks for a word
        function bit note_item(row_item_t it);
            int prow;
            int crow;
            int bit_idx;
            int w;
            logic [WORD_BITS-1:0] owed;
            if (it.kind == KIND_READ)
            begin
                if (it.read_word < WORDS && row_live[it.read_row])
                    owed = edge_flags[it.read_row][it.read_word];
                else
                    owed = '0;
                expected_words = {expected_words, owed};
                return 1'b1;
            end
            // clearing happens even when the rest of the edge is dropped
            if (it.new_tree)
                foreach (row_live[r])
                    row_live[r] = 1'b0;
            if (it.edge_number == 0 || it.edge_number > MAX_EDGES)
                return 1'b0;
            if (it.parent_node <= tip_count)
                return 1'b0;
            prow = int'(it.parent_node) - int'(tip_count) - 1;
            if (prow >= ROWS)
                return 1'b0;
            if (!row_live[prow])
            begin
                for (w = 0; w < WORDS; w++)
                    edge_flags[prow][w] = '0;
                row_live[prow] = 1'b1;
            end
            bit_idx = int'(it.edge_number) - 1;
            edge_flags[prow][bit_idx / WORD_BITS][bit_idx % WORD_BITS] = 1'b1;
            // internal child: merge its row, empty if out of range or never written
            if (it.child_node > tip_count)
            begin
                crow = int'(it.child_node) - int'(tip_count) - 1;
                if (crow < ROWS && row_live[crow])
                    for (w = 0; w < WORDS; w++)
                        edge_flags[prow][w] |= edge_flags[crow][w];
            end
            edges_applied++;
            return 1'b1;
        endfunction

        function void check_word(logic [WORD_BITS-1:0] got);
            logic [WORD_BITS-1:0] want;
            if (expected_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("ERROR: row_word %h transferred with nothing pending", got);
                return;
            end
            want = expected_words.pop_front();
            words_checked++;
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("ERROR: row_word expected %h, got %h", want, got);
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [NODE_W-1:0]     cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic                  kind;
    logic                  new_tree;
    logic [EDGE_W-1:0]     edge_number;
    logic [NODE_W-1:0]     parent_node;
    logic [NODE_W-1:0]     child_node;
    logic [ROW_W-1:0]      read_row;
    logic [WORD_SEL_W-1:0] read_word;
    logic                  out_valid;
    logic                  out_ready;
    logic [WORD_BITS-1:0]  row_word;

    row_word_scoreboard sb;
    int burst_left;
    int useful_items;
    int trees_built;
    int settings_used;
    int ready_mode;
    int ready_hold;

    tree_descendant_edge_sets i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .new_tree    (new_tree),
        .edge_number (edge_number),
        .parent_node (parent_node),
        .child_node  (child_node),
        .read_row    (read_row),
        .read_word   (read_word),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .row_word    (row_word)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Receiver: alternates between steady, random, stalled and toggling stretches
    always @(posedge clk)
    begin
        if (ready_hold <= 0)
        begin
            ready_mode = $urandom_range(RDY_STEADY, RDY_TOGGLE);
            case (ready_mode)
                RDY_STEADY: ready_hold = $urandom_range(20, 200);
                RDY_RANDOM: ready_hold = $urandom_range(10, 60);
                RDY_STALL:  ready_hold = $urandom_range(1, 25);
                default:    ready_hold = $urandom_range(10, 40);
            endcase
        end
        ready_hold--;
        case (ready_mode)
            RDY_STEADY: out_ready <= 1'b1;
            RDY_RANDOM: out_ready <= 1'($urandom_range(0, 1));
            RDY_STALL:  out_ready <= 1'b0;
            default:    out_ready <= ready_hold[0];
        endcase
    end

    // Result check on every output transfer
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_word(row_word);
    end

    // Watchdog: ends the run after too many cycles without any transfer
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready)
                || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("tree_descendant_edge_sets_tb: FAIL");
        $finish;
    end

    function automatic row_item_t edge_item(bit fresh, int num, int parent, int child);
        row_item_t it;
        it.kind        = KIND_EDGE;
        it.new_tree    = fresh;
        it.edge_number = EDGE_W'(num);
        it.parent_node = NODE_W'(parent);
        it.child_node  = NODE_W'(child);
        it.read_row    = ROW_W'($urandom);
        it.read_word   = WORD_SEL_W'($urandom);
        return it;
    endfunction

    function automatic row_item_t read_item(int row, int word);
        row_item_t it;
        it.kind        = KIND_READ;
        it.new_tree    = 1'($urandom_range(0, 1));
        it.edge_number = EDGE_W'($urandom);
        it.parent_node = NODE_W'($urandom);
        it.child_node  = NODE_W'($urandom);
        it.read_row    = ROW_W'(row);
        it.read_word   = WORD_SEL_W'(word);
        return it;
    endfunction

    // Sender: bursts of random length separated by random gaps
    task automatic push_item(input row_item_t it);
        int gap;
        if (burst_left <= 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 24);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        kind        <= it.kind;
        new_tree    <= it.new_tree;
        edge_number <= it.edge_number;
        parent_node <= it.parent_node;
        child_node  <= it.child_node;
        read_row    <= it.read_row;
        read_word   <= it.read_word;
        in_valid    <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if (sb.note_item(it))
            useful_items++;
    endtask

    // Hold off the sender until every owed word has been transferred
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
    endtask

    task automatic write_tip_count(input int value);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_data  <= NODE_W'(value);
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        sb.tip_count = NODE_W'(value);
        settings_used++;
    endtask

    // One random tree in postorder: each new internal node adopts open subtrees or tips
    task automatic build_tree(input int edge_budget);
        int tips;
        int row_span;
        int num;
        int parent;
        int child;
        int pick;
        int r;
        int n_reads;
        int roots [$];
        int spare_rows [$];
        int used_rows [$];
        bit fresh;
        tips = int'(sb.tip_count);
        row_span = (511 - tips < ROWS) ? 511 - tips : ROWS;
        for (r = 0; r < row_span; r++)
            spare_rows = {spare_rows, r};
        fresh = ($urandom_range(0, 6) != 0);
        num = 1;
        while (num <= edge_budget && spare_rows.size() > 0)
        begin
            pick = $urandom_range(0, spare_rows.size() - 1);
            parent = tips + 1 + spare_rows[pick];
            used_rows = {used_rows, spare_rows[pick]};
            spare_rows.delete(pick);
            repeat ($urandom_range(1, 3))
            begin
                if (num > edge_budget)
                    break;
                if (roots.size() > 0 && $urandom_range(0, 2) != 0)
                begin
                    pick = $urandom_range(0, roots.size() - 1);
                    child = roots[pick];
                    roots.delete(pick);
                end
                else
                    child = $urandom_range(1, tips);
                push_item(edge_item(fresh, num, parent, child));
                fresh = 1'b0;
                num++;
                // look at a half-built row now and then
                if ($urandom_range(0, 9) == 0)
                    push_item(read_item(used_rows[$urandom_range(0, used_rows.size() - 1)],
                                        $urandom_range(0, 3)));
            end
            roots = {roots, parent};
        end
        // read back the rows of this tree, plus one row picked blindly
        n_reads = (used_rows.size() < 12) ? 2 * used_rows.size() : 24;
        repeat (n_reads)
            push_item(read_item(used_rows[$urandom_range(0, used_rows.size() - 1)],
                                $urandom_range(0, 3)));
        push_item(read_item($urandom_range(0, ROWS - 1), $urandom_range(0, 3)));
        trees_built++;
    endtask

    task automatic run_phase(input int tips_setting);
        int start;
        int pick;
        write_tip_count(tips_setting);
        start = useful_items;
        while (useful_items - start < ITEMS_PER_PHASE)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 75)
                build_tree(($urandom_range(0, 9) == 0) ? $urandom_range(100, MAX_EDGES)
                                                       : $urandom_range(2, 40));
            else if (pick < 97)
                // noise: any field value, mostly ignored or out-of-order edges
                repeat ($urandom_range(1, 6))
                begin
                    if ($urandom_range(0, 1) == 1)
                        push_item(read_item($urandom_range(0, ROWS - 1),
                                            $urandom_range(0, 3)));
                    else
                        push_item(edge_item(($urandom_range(0, 15) == 0),
                                            $urandom_range(0, 511), $urandom_range(0, 511),
                                            $urandom_range(0, 511)));
                end
            else
                drain_results();
        end
    endtask

    // Main sequence: reset, directed corner cases, then random phases per tip_count
    initial
    begin
        sb = new();
        burst_left    = 0;
        useful_items  = 0;
        trees_built   = 0;
        settings_used = 0;
        ready_mode    = RDY_STEADY;
        ready_hold    = 0;
        rst_n       <= 1'b0;
        cfg_valid   <= 1'b0;
        cfg_data    <= '0;
        in_valid    <= 1'b0;
        kind        <= KIND_EDGE;
        new_tree    <= 1'b0;
        edge_number <= '0;
        parent_node <= '0;
        child_node  <= '0;
        read_row    <= '0;
        read_word   <= '0;
        out_ready   <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, tip_count at its reset value of 2 (node 3 owns row 0)
        push_item(read_item(0, 0));                  // row never written
        push_item(edge_item(1'b1, 1, 3, 1));         // first edge, starts a tree
        push_item(edge_item(1'b0, MAX_EDGES, 3, 2)); // top bit of the last word
        push_item(edge_item(1'b0, 2, 4, 3));         // internal child merged in
        push_item(edge_item(1'b0, 3, 4, 4));         // child is the parent itself
        push_item(edge_item(1'b0, 0, 4, 1));         // edge zero dropped
        push_item(edge_item(1'b0, MAX_EDGES + 1, 4, 1));
        push_item(edge_item(1'b0, 511, 4, 1));
        push_item(edge_item(1'b0, 4, 2, 1));         // parent is a tip
        push_item(edge_item(1'b0, 5, 0, 1));
        push_item(edge_item(1'b0, 6, 511, 3));       // parent row beyond the table
        push_item(edge_item(1'b0, 7, 258, 4));       // last row
        push_item(edge_item(1'b0, 8, 5, 511));       // child row beyond the table
        push_item(edge_item(1'b0, 9, 5, 10));        // child row never written
        push_item(edge_item(1'b0, 64, 5, 3));        // word boundary
        push_item(edge_item(1'b0, 65, 5, 3));
        push_item(read_item(0, 3));
        push_item(read_item(1, 0));
        push_item(read_item(1, 3));
        push_item(read_item(ROWS - 1, 0));
        push_item(read_item(2, 1));
        push_item(read_item(7, 0));
        push_item(edge_item(1'b1, 0, 3, 1));         // clear rides on a dropped edge
        push_item(read_item(0, 0));
        push_item(read_item(ROWS - 1, 3));

        // random phases, extremes of tip_count included
        run_phase(1);
        run_phase(256);
        run_phase($urandom_range(3, 64));
        run_phase(255);
        run_phase($urandom_range(1, 256));

        drain_results();
        repeat (2 * SETTLE_CYCLES) @(posedge clk);

        $display("covered %0d trees over %0d tip_count settings, %0d edges applied",
                 trees_built, settings_used, sb.edges_applied);
        $display("checked %0d row words, %0d mismatches", sb.words_checked, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("tree_descendant_edge_sets_tb: PASS");
        else
            $display("tree_descendant_edge_sets_tb: FAIL");
        $finish;
    end

endmodule
